FILE: hdl/shac_pkg.sv
// Shared types, constants and round functions of the SHA-256 compression block.
package shac_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned NumChain   = 8;
  localparam int unsigned SchedDepth = 16;
  localparam int unsigned NumRounds  = 64;
  localparam int unsigned CfgIdxW    = 4;

  typedef logic [WordWidth-1:0] word_t;

  localparam word_t RoundK [NumRounds] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam word_t InitReset [NumChain] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Schedule window control: load shifts in a message word, step shifts
  // in an expanded word.
  typedef struct packed {
    logic load;
    logic step;
  } sched_ctrl_t;

  // Round core control: init copies the chaining value, step runs a round.
  typedef struct packed {
    logic init;
    logic step;
  } core_ctrl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordWidth - n));
  endfunction

  function automatic word_t small_sig0(input word_t x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

FILE: hdl/sha256_compression_unit.sv
// Top level: sequencer, chaining value, initial-value registers and digest output.
//
// Message words arrive on the message channel (valid/ready), sixteen per
// padded 512-bit block. The first fifteen words go in one per cycle while valid.
// The sixteenth starts the compression: 64 rounds, one per cycle, on the
// single round core, then a final add of the working variables into the
// chaining value. Message ready stays low through the rounds and the add.
// If the sixteenth word carried emit_digest, the eight chaining words then
// go out on the digest channel, word_index 0 first, with last on the eighth.
// While the digest is offered, message ready stays low; a stalled receiver
// holds the current word in place until it is taken.
// first_block on a block's first word loads the chaining value from the
// init_word registers, written through the cfg port. The user must write
// them only while the block idles; the block itself does not enforce it.
// Synchronous reset clears the chaining value and the word count and
// restores the init_word registers to the standard SHA-256 initial value.
module sha256_compression_unit import shac_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               message_valid,
  output logic               message_ready,
  input  logic [31:0]        message_word,
  input  logic               first_block,
  input  logic               emit_digest,
  output logic               digest_valid,
  input  logic               digest_ready,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  state_t      state;
  logic [3:0]  word_count;
  logic [5:0]  round;
  logic [2:0]  out_idx;
  logic        emit;
  word_t       init_word [NumChain];
  word_t       chain [NumChain];
  word_t       vars [NumChain];
  word_t       round_word;
  logic        in_xfer;
  logic        out_xfer;
  sched_ctrl_t sched_ctrl;
  core_ctrl_t  core_ctrl;

  assign message_ready = (state == ST_LOAD);
  assign digest_valid  = (state == ST_EMIT);
  assign in_xfer       = message_valid && message_ready;
  assign out_xfer      = digest_valid && digest_ready;
  assign digest_word   = chain[out_idx];
  assign word_index    = out_idx;
  assign last          = (out_idx == 3'(NumChain - 1));

  assign sched_ctrl.load = in_xfer;
  assign sched_ctrl.step = (state == ST_ROUND);
  assign core_ctrl.init  = in_xfer && (word_count == 4'(SchedDepth - 1));
  assign core_ctrl.step  = (state == ST_ROUND);

  shac_sched u_sched (
    .clk          (clk),
    .ctrl         (sched_ctrl),
    .message_word (message_word),
    .round_word   (round_word)
  );

  shac_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (core_ctrl),
    .chain      (chain),
    .round_k    (RoundK[round]),
    .round_word (round_word),
    .vars       (vars)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      word_count <= '0;
      round      <= '0;
      out_idx    <= '0;
      emit       <= 1'b0;
      init_word  <= InitReset;
      for (int i = 0; i < NumChain; i++) begin
        chain[i] <= '0;
      end
    end else begin
      if (cfg_write && (cfg_index < CfgIdxW'(NumChain))) begin
        init_word[cfg_index[2:0]] <= cfg_data;
      end
      case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if ((word_count == '0) && first_block) begin
              chain <= init_word;
            end
            word_count <= word_count + 4'd1;
            if (word_count == 4'(SchedDepth - 1)) begin
              emit  <= emit_digest;
              round <= '0;
              state <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          round <= round + 6'd1;
          if (round == 6'(NumRounds - 1)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < NumChain; i++) begin
            chain[i] <= chain[i] + vars[i];
          end
          out_idx <= '0;
          state   <= emit ? ST_EMIT : ST_LOAD;
        end
        ST_EMIT: begin
          if (out_xfer) begin
            out_idx <= out_idx + 3'd1;
            if (last) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(message_ready && digest_valid))
    else $error("message and digest channels active together");

  a_block_starts_rounds: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (word_count == 4'(SchedDepth - 1))) |=> (!message_ready && (round == '0)))
    else $error("sixteenth word did not start the rounds");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> (word_count == '0))
    else $error("word count not at block start during compression");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && last) |=> message_ready)
    else $error("input not ready after last digest word");

  a_rounds_end_in_add: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_ROUND) && (round == 6'(NumRounds - 1))) |=> (state == ST_ADD))
    else $error("round loop did not end in the final add");
`endif

endmodule

FILE: hdl/shac_sched.sv
// Rolling 16-word message schedule held in a shift line.
module shac_sched import shac_pkg::*; (
  input  logic        clk,
  input  sched_ctrl_t ctrl,
  input  word_t       message_word,
  output word_t       round_word
);

  word_t w [SchedDepth];
  word_t expanded;

  // Tap 0 holds W[r]; the new word is W[r+16].
  assign expanded = w[0] + small_sig0(w[1]) + w[9] + small_sig1(w[14]);
  assign round_word = w[0];

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.step) begin
      for (int i = 0; i < SchedDepth - 1; i++) begin
        w[i] <= w[i+1];
      end
      w[SchedDepth-1] <= ctrl.load ? message_word : expanded;
    end
  end

endmodule

FILE: hdl/shac_core.sv
// Working variables a..h and the round function, one round per cycle while step is set.
module shac_core import shac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  core_ctrl_t ctrl,
  input  word_t      chain [NumChain],
  input  word_t      round_k,
  input  word_t      round_word,
  output word_t      vars [NumChain]
);

  word_t v [NumChain];
  word_t t1;
  word_t t2;

  assign t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k + round_word;
  assign t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign vars = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumChain; i++) begin
        v[i] <= '0;
      end
    end else if (ctrl.init) begin
      v <= chain;
    end else if (ctrl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule
